[src/ecc_pkg.sv]
// ============================================================================
// ecc_pkg: shared types, constants and date tables
// Constants, reciprocal multipliers and the four-year month-start table used
// by the epoch / calendar converter pipeline.
// ============================================================================
package ecc_pkg;

    // Calendar limits
    localparam int unsigned MAX_EPOCH    = 32'd4102444799;
    localparam int unsigned BASE_YEAR    = 1970;
    localparam int unsigned LAST_YEAR    = 2099;
    localparam int unsigned CYCLE_YEARS  = 4;
    localparam int unsigned CYCLE_DAYS   = 365 * 4 + 1;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned BASE_WEEKDAY = 4;
    localparam int unsigned SEC_PER_HOUR = 60 * 60;
    localparam int unsigned SEC_PER_DAY  = 60 * 60 * 24;

    // Reciprocals: x/15 = (x*RECIP_15)>>34 for x < 2^30,
    // x/3 = (x*RECIP_3)>>20 for x < 2^19,
    // x/1461 = (x*RECIP_1461)>>26 and x/7 = (x*RECIP_7)>>19 for x < 2^16
    localparam int unsigned RECIP_15   = 1145324613;
    localparam int unsigned RECIP_3    = 349526;
    localparam int unsigned RECIP_1461 = 45934;
    localparam int unsigned RECIP_7    = 74899;

    // Cumulative month starts over the four-year cycle, leap year in row 2
    localparam logic [10:0] MONTH_START [0:3][0:11] = '{
        '{11'd0,    11'd31,   11'd59,   11'd90,   11'd120,  11'd151,
          11'd181,  11'd212,  11'd243,  11'd273,  11'd304,  11'd334},
        '{11'd365,  11'd396,  11'd424,  11'd455,  11'd485,  11'd516,
          11'd546,  11'd577,  11'd608,  11'd638,  11'd669,  11'd699},
        '{11'd730,  11'd761,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    // Conversion direction
    typedef enum logic {
        ACT_TO_CAL   = 1'b0,
        ACT_TO_EPOCH = 1'b1
    } t_action;

    // Calendar and time-of-day fields
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cal;

    // Front end to date stages
    typedef struct packed {
        logic        valid;
        t_action     action;
        logic        err;
        logic [15:0] days;
        logic [31:0] epoch;
        t_cal        cal;
    } t_front;

    // Date stages to output stage
    typedef struct packed {
        t_front      info;
        logic [1:0]  row;
        logic [3:0]  mon;
        logic [10:0] rem;
        logic [11:0] year0;
        logic [2:0]  weekday;
    } t_date;

    // Day offset of a month start inside the cycle; meaningless months give 0
    function automatic logic [10:0] month_start(input logic [1:0] row,
                                                input logic [3:0] mon);
        logic [10:0] res;
        if (mon > 4'd11) begin
            res = 11'd0;
        end else begin
            res = MONTH_START[row][mon];
        end
        return res;
    endfunction

    // Length of a month in days
    function automatic logic [4:0] month_len(input logic [1:0] row,
                                             input logic [3:0] mon);
        logic [10:0] s;
        logic [10:0] e;
        s = month_start(row, mon);
        if (mon < 4'd11) begin
            e = month_start(row, mon + 4'd1);
        end else if (row < 2'd3) begin
            e = month_start(row + 2'd1, 4'd0);
        end else begin
            e = 11'(CYCLE_DAYS);
        end
        return 5'(e - s);
    endfunction

endpackage

[src/ecc_front.sv]
// ============================================================================
// ecc_front: time-of-day split and epoch build
// Four register stages: splits seconds into second, minute, hour and day
// count by reciprocal multiplies, or checks calendar fields and builds the
// day count and epoch seconds from them.
// ============================================================================
module ecc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_action,
    input  logic [31:0]         i_epoch_seconds,
    input  logic [11:0]         i_year,
    input  logic [3:0]          i_month,
    input  logic [4:0]          i_day,
    input  logic [4:0]          i_hour,
    input  logic [5:0]          i_minute,
    input  logic [5:0]          i_second,
    output ecc_pkg::t_front     o_front
);

    // ---------------- stage A ----------------
    logic                r_a_valid;
    ecc_pkg::t_action    r_a_action;
    logic                r_a_err;
    logic [31:0]         r_a_t;
    logic [26:0]         r_a_q1;
    logic [5:0]          r_a_cyc;
    logic [10:0]         r_a_dic;
    logic [16:0]         r_a_hms;
    ecc_pkg::t_cal       r_a_cal;

    logic [60:0]         prod_a;
    logic [7:0]          yoff;
    logic [1:0]          row_a;
    logic [3:0]          mon_a;
    logic [4:0]          mlen_a;
    logic                bad_a;
    logic [26:0]         n_a_q1;
    logic                n_a_err;
    logic [10:0]         n_a_dic;
    logic [16:0]         n_a_hms;

    // minute count by reciprocal, calendar checks, offsets within the cycle
    always_comb begin
        prod_a  = 61'(i_epoch_seconds[31:2]) * 61'(ecc_pkg::RECIP_15);
        n_a_q1  = prod_a[60:34];
        yoff    = 8'(i_year - 12'(ecc_pkg::BASE_YEAR));
        row_a   = yoff[1:0];
        mon_a   = i_month - 4'd1;
        mlen_a  = ecc_pkg::month_len(row_a, mon_a);
        bad_a   = (i_year < ecc_pkg::BASE_YEAR) || (i_year > ecc_pkg::LAST_YEAR) ||
                  (i_month < 4'd1) || (i_month > 4'd12) ||
                  (i_hour >= ecc_pkg::HOUR_PER_DAY) ||
                  (i_minute >= ecc_pkg::SEC_PER_MIN) ||
                  (i_second >= ecc_pkg::SEC_PER_MIN) ||
                  (i_day == 5'd0) || (i_day > mlen_a);
        if (ecc_pkg::t_action'(i_action) == ecc_pkg::ACT_TO_EPOCH) begin
            n_a_err = bad_a;
        end else begin
            n_a_err = (i_epoch_seconds > ecc_pkg::MAX_EPOCH);
        end
        n_a_dic = ecc_pkg::month_start(row_a, mon_a) + 11'(i_day) - 11'd1;
        n_a_hms = 17'(i_hour) * 17'(ecc_pkg::SEC_PER_HOUR)
                + 17'(i_minute) * 17'(ecc_pkg::SEC_PER_MIN) + 17'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
        r_a_action     <= ecc_pkg::t_action'(i_action);
        r_a_err        <= n_a_err;
        r_a_t          <= i_epoch_seconds;
        r_a_q1         <= n_a_q1;
        r_a_cyc        <= yoff[7:2];
        r_a_dic        <= n_a_dic;
        r_a_hms        <= n_a_hms;
        r_a_cal.year   <= i_year;
        r_a_cal.month  <= i_month;
        r_a_cal.day    <= i_day;
        r_a_cal.hour   <= i_hour;
        r_a_cal.minute <= i_minute;
        r_a_cal.second <= i_second;
    end

    // ---------------- stage B ----------------
    logic                r_b_valid;
    ecc_pkg::t_action    r_b_action;
    logic                r_b_err;
    logic [31:0]         r_b_t;
    logic [26:0]         r_b_q1;
    logic [5:0]          r_b_sec;
    logic [20:0]         r_b_q2;
    logic [15:0]         r_b_days1;
    logic [16:0]         r_b_hms;
    ecc_pkg::t_cal       r_b_cal;

    logic [31:0]         diff_b;
    logic [55:0]         prod_b;
    logic [15:0]         n_b_days1;

    // seconds remainder, hour count, day count of a calendar request
    always_comb begin
        diff_b    = r_a_t - 32'(r_a_q1) * 32'(ecc_pkg::SEC_PER_MIN);
        prod_b    = 56'(r_a_q1[26:2]) * 56'(ecc_pkg::RECIP_15);
        n_b_days1 = 16'(r_a_cyc) * 16'(ecc_pkg::CYCLE_DAYS) + 16'(r_a_dic);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_action <= r_a_action;
        r_b_err    <= r_a_err;
        r_b_t      <= r_a_t;
        r_b_q1     <= r_a_q1;
        r_b_sec    <= diff_b[5:0];
        r_b_q2     <= prod_b[54:34];
        r_b_days1  <= n_b_days1;
        r_b_hms    <= r_a_hms;
        r_b_cal    <= r_a_cal;
    end

    // ---------------- stage C ----------------
    logic                r_c_valid;
    ecc_pkg::t_action    r_c_action;
    logic                r_c_err;
    logic [31:0]         r_c_t;
    logic [5:0]          r_c_sec;
    logic [5:0]          r_c_min;
    logic [20:0]         r_c_q2;
    logic [15:0]         r_c_days0;
    logic [15:0]         r_c_days1;
    logic [31:0]         r_c_epoch1;
    ecc_pkg::t_cal       r_c_cal;

    logic [26:0]         diff_c;
    logic [36:0]         prod_c;
    logic [31:0]         n_c_epoch1;

    // minute remainder, day count by /24, epoch of a calendar request
    always_comb begin
        diff_c     = r_b_q1 - 27'(r_b_q2) * 27'(ecc_pkg::SEC_PER_MIN);
        prod_c     = 37'(r_b_q2[20:3]) * 37'(ecc_pkg::RECIP_3);
        n_c_epoch1 = 32'(r_b_days1) * 32'(ecc_pkg::SEC_PER_DAY) + 32'(r_b_hms);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_action <= r_b_action;
        r_c_err    <= r_b_err;
        r_c_t      <= r_b_t;
        r_c_sec    <= r_b_sec;
        r_c_min    <= diff_c[5:0];
        r_c_q2     <= r_b_q2;
        r_c_days0  <= prod_c[35:20];
        r_c_days1  <= r_b_days1;
        r_c_epoch1 <= n_c_epoch1;
        r_c_cal    <= r_b_cal;
    end

    // ---------------- stage D ----------------
    ecc_pkg::t_front     r_front;
    ecc_pkg::t_front     n_front;
    logic [20:0]         diff_d;

    // hour remainder and merge of both directions
    always_comb begin
        diff_d         = r_c_q2 - 21'(r_c_days0) * 21'(ecc_pkg::HOUR_PER_DAY);
        n_front.valid  = r_c_valid;
        n_front.action = r_c_action;
        n_front.err    = r_c_err;
        n_front.cal    = r_c_cal;
        if (r_c_action == ecc_pkg::ACT_TO_EPOCH) begin
            n_front.days  = r_c_days1;
            n_front.epoch = r_c_epoch1;
        end else begin
            n_front.days       = r_c_days0;
            n_front.epoch      = r_c_t;
            n_front.cal.hour   = diff_d[4:0];
            n_front.cal.minute = r_c_min;
            n_front.cal.second = r_c_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

[src/ecc_date.sv]
// ============================================================================
// ecc_date: day count to cycle, weekday and month
// Three register stages: four-year cycle and week by reciprocal multiplies,
// remainders and weekday, then row and month search over the cycle table.
// ============================================================================
module ecc_date (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ecc_pkg::t_front     i_front,
    output ecc_pkg::t_date      o_date
);

    // ---------------- stage E: quotients ----------------
    ecc_pkg::t_front     r_e;
    logic [5:0]          r_e_cyc;
    logic [13:0]         r_e_wq;
    logic [31:0]         prod_cyc;
    logic [32:0]         prod_wk;

    always_comb begin
        prod_cyc = 32'(i_front.days) * 32'(ecc_pkg::RECIP_1461);
        prod_wk  = 33'(i_front.days) * 33'(ecc_pkg::RECIP_7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else begin
            r_e <= i_front;
        end
        r_e_cyc <= prod_cyc[31:26];
        r_e_wq  <= prod_wk[32:19];
    end

    // ---------------- stage F: remainders and weekday ----------------
    ecc_pkg::t_front     r_f;
    logic [10:0]         r_f_rem;
    logic [2:0]          r_f_wday;
    logic [11:0]         r_f_year0;
    logic [15:0]         diff_cyc;
    logic [15:0]         diff_wk;
    logic [3:0]          wsum;
    logic [2:0]          n_f_wday;

    always_comb begin
        diff_cyc = r_e.days - 16'(r_e_cyc) * 16'(ecc_pkg::CYCLE_DAYS);
        diff_wk  = r_e.days - 16'(r_e_wq) * 16'(ecc_pkg::DAYS_PER_WEEK);
        // day 0 was a Thursday; Sunday reads as 7
        wsum     = 4'(diff_wk[2:0]) + 4'(ecc_pkg::BASE_WEEKDAY);
        if (wsum >= 4'(ecc_pkg::DAYS_PER_WEEK)) begin
            wsum = wsum - 4'(ecc_pkg::DAYS_PER_WEEK);
        end
        if (wsum == 4'd0) begin
            n_f_wday = 3'(ecc_pkg::DAYS_PER_WEEK);
        end else begin
            n_f_wday = wsum[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f.valid <= 1'b0;
        end else begin
            r_f <= r_e;
        end
        r_f_rem   <= diff_cyc[10:0];
        r_f_wday  <= n_f_wday;
        r_f_year0 <= 12'(ecc_pkg::BASE_YEAR) + 12'(r_e_cyc) * 12'(ecc_pkg::CYCLE_YEARS);
    end

    // ---------------- stage G: row and month search ----------------
    ecc_pkg::t_date      r_date;
    logic [1:0]          row_g;
    logic [3:0]          mon_g;

    always_comb begin
        if (r_f_rem >= ecc_pkg::month_start(2'd3, 4'd0)) begin
            row_g = 2'd3;
        end else if (r_f_rem >= ecc_pkg::month_start(2'd2, 4'd0)) begin
            row_g = 2'd2;
        end else if (r_f_rem >= ecc_pkg::month_start(2'd1, 4'd0)) begin
            row_g = 2'd1;
        end else begin
            row_g = 2'd0;
        end
        // independent compares, the last start passed wins
        mon_g = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (r_f_rem >= ecc_pkg::month_start(row_g, 4'(m))) begin
                mon_g = 4'(m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.info.valid <= 1'b0;
        end else begin
            r_date.info <= r_f;
        end
        r_date.row     <= row_g;
        r_date.mon     <= mon_g;
        r_date.rem     <= r_f_rem;
        r_date.year0   <= r_f_year0;
        r_date.weekday <= r_f_wday;
    end

    assign o_date = r_date;

endmodule

[src/epoch_calendar_converter_top.sv]
// ============================================================================
// epoch_calendar_converter_top: epoch seconds / calendar converter
// Throughput: one request per clock; busy stays low, the eight-stage
// reciprocal-multiply pipeline takes a new request every cycle.
// Reset: synchronous, active low; clears the stage valid bits only.
// Results cannot be held off by the receiver; each shows for one cycle.
// ============================================================================
module epoch_calendar_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [31:0] i_epoch_seconds_in,
    input  logic [11:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    input  logic [4:0]  i_hour_in,
    input  logic [5:0]  i_minute_in,
    input  logic [5:0]  i_second_in,
    output logic        o_strobe,
    output logic [31:0] o_epoch_seconds_out,
    output logic [11:0] o_year_out,
    output logic [3:0]  o_month_out,
    output logic [4:0]  o_day_out,
    output logic [4:0]  o_hour_out,
    output logic [5:0]  o_minute_out,
    output logic [5:0]  o_second_out,
    output logic [2:0]  o_weekday_out,
    output logic        o_range_error
);

    ecc_pkg::t_front front;
    ecc_pkg::t_date  date;

    // pipeline never blocks a request
    assign busy = 1'b0;

    ecc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start),
        .i_action        (i_action),
        .i_epoch_seconds (i_epoch_seconds_in),
        .i_year          (i_year_in),
        .i_month         (i_month_in),
        .i_day           (i_day_in),
        .i_hour          (i_hour_in),
        .i_minute        (i_minute_in),
        .i_second        (i_second_in),
        .o_front         (front)
    );

    ecc_date u_date (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .o_date  (date)
    );

    // ---------------- output stage ----------------
    logic               r_strobe;
    logic [31:0]        r_epoch;
    ecc_pkg::t_cal      r_cal;
    logic [2:0]         r_wday;
    logic               r_err;

    logic [10:0]        day_sum;
    logic [31:0]        n_epoch;
    ecc_pkg::t_cal      n_cal;
    logic [2:0]         n_wday;

    // day of month, full year, and zeroing of a failed request
    always_comb begin
        day_sum = date.rem - ecc_pkg::month_start(date.row, date.mon) + 11'd1;
        n_epoch = date.info.epoch;
        n_cal   = date.info.cal;
        n_wday  = date.weekday;
        if (date.info.action == ecc_pkg::ACT_TO_CAL) begin
            n_cal.year  = date.year0 + 12'(date.row);
            n_cal.month = date.mon + 4'd1;
            n_cal.day   = day_sum[4:0];
        end
        if (date.info.err) begin
            n_epoch = 32'd0;
            n_cal   = '0;
            n_wday  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= date.info.valid;
        end
        r_epoch <= n_epoch;
        r_cal   <= n_cal;
        r_wday  <= n_wday;
        r_err   <= date.info.err;
    end

    assign o_strobe            = r_strobe;
    assign o_epoch_seconds_out = r_epoch;
    assign o_year_out          = r_cal.year;
    assign o_month_out         = r_cal.month;
    assign o_day_out           = r_cal.day;
    assign o_hour_out          = r_cal.hour;
    assign o_minute_out        = r_cal.minute;
    assign o_second_out        = r_cal.second;
    assign o_weekday_out       = r_wday;
    assign o_range_error       = r_err;

    // ---------------- assertions ----------------
    // every result traces back to a request taken earlier
    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 8))
        else $error("result strobe without a matching request");

    // a failed request carries only the error flag
    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_range_error) |-> (o_epoch_seconds_out == 32'd0 &&
            o_year_out == 12'd0 && o_month_out == 4'd0 && o_day_out == 5'd0 &&
            o_hour_out == 5'd0 && o_minute_out == 6'd0 && o_second_out == 6'd0 &&
            o_weekday_out == 3'd0))
        else $error("fields not cleared on range error");

    // a good result is a real date and time
    a_good_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_range_error) |-> (o_weekday_out != 3'd0 &&
            o_month_out != 4'd0 && o_month_out <= 4'd12 && o_day_out != 5'd0 &&
            o_hour_out < 5'd24 && o_minute_out < 6'd60 && o_second_out < 6'd60 &&
            o_year_out >= 12'd1970 && o_year_out <= 12'd2099))
        else $error("result fields out of range");

endmodule

[bench/tb_epoch_calendar_converter_top.sv]
// ============================================================================
// tb_epoch_calendar_converter_top: self-checking bench for the epoch converter
// Sends seconds-to-date and date-to-seconds requests with random gaps or back to back, and
// models every conversion inside the bench. Each strobed result is compared
// field by field, in order, against the modelled one.
// ============================================================================
module tb_epoch_calendar_converter_top;

    localparam int unsigned IDLE_MAX       = 13;
    localparam int unsigned RESULT_LATENCY = 8;

    // One conversion request as the ports see it
    typedef struct {
        ecc_pkg::t_action action;
        logic [31:0]      epoch;
        ecc_pkg::t_cal    cal;
    } t_conv_request;

    // One conversion result
    typedef struct {
        logic [31:0]   epoch;
        ecc_pkg::t_cal cal;
        logic [2:0]    weekday;
        logic          err;
    } t_conv_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_action;
    logic [31:0] i_epoch_seconds_in;
    logic [11:0] i_year_in;
    logic [3:0]  i_month_in;
    logic [4:0]  i_day_in;
    logic [4:0]  i_hour_in;
    logic [5:0]  i_minute_in;
    logic [5:0]  i_second_in;
    logic        o_strobe;
    logic [31:0] o_epoch_seconds_out;
    logic [11:0] o_year_out;
    logic [3:0]  o_month_out;
    logic [4:0]  o_day_out;
    logic [4:0]  o_hour_out;
    logic [5:0]  o_minute_out;
    logic [5:0]  o_second_out;
    logic [2:0]  o_weekday_out;
    logic        o_range_error;

    t_conv_result expected_dates[$];
    bit           gaps_on = 1'b1;
    int unsigned  fail_count = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_split = 0;
    int unsigned  n_build = 0;
    int unsigned  n_out_of_range = 0;

    epoch_calendar_converter_top dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Calendar model
    // ------------------------------------------------------------------

    // Days in month mon (0-based) of cycle row; leap year sits in row 2
    function automatic int unsigned month_days(input int unsigned row,
                                               input int unsigned mon);
        int unsigned last;
        if (mon < 11) begin
            last = ecc_pkg::MONTH_START[row][mon + 1];
        end else if (row < 3) begin
            last = ecc_pkg::MONTH_START[row + 1][0];
        end else begin
            last = ecc_pkg::CYCLE_DAYS;
        end
        return last - ecc_pkg::MONTH_START[row][mon];
    endfunction

    // 1970-01-01 was a Thursday; Sunday reads as 7
    function automatic logic [2:0] weekday_of_day(input longint unsigned days);
        longint unsigned w;
        w = (days + ecc_pkg::BASE_WEEKDAY) % ecc_pkg::DAYS_PER_WEEK;
        return (w == 0) ? 3'd7 : 3'(w);
    endfunction

    function automatic t_conv_result predict_conversion(input t_conv_request rq);
        t_conv_result    res;
        longint unsigned secs;
        longint unsigned days;
        longint unsigned rem;
        int unsigned     row;
        int unsigned     mon;
        int unsigned     yoff;
        bit              bad;
        res = '{default: '0};
        if (rq.action == ecc_pkg::ACT_TO_CAL) begin
            secs = rq.epoch;
            if (secs > ecc_pkg::MAX_EPOCH) begin
                res.err = 1'b1;
                return res;
            end
            res.epoch      = rq.epoch;
            res.cal.second = 6'(secs % ecc_pkg::SEC_PER_MIN);
            secs           = secs / ecc_pkg::SEC_PER_MIN;
            res.cal.minute = 6'(secs % ecc_pkg::SEC_PER_MIN);
            secs           = secs / ecc_pkg::SEC_PER_MIN;
            res.cal.hour   = 5'(secs % ecc_pkg::HOUR_PER_DAY);
            days           = secs / ecc_pkg::HOUR_PER_DAY;
            res.weekday    = weekday_of_day(days);
            rem            = days % ecc_pkg::CYCLE_DAYS;
            row = 3;
            while (row > 0 && rem < ecc_pkg::MONTH_START[row][0]) row--;
            mon = 11;
            while (mon > 0 && rem < ecc_pkg::MONTH_START[row][mon]) mon--;
            res.cal.year  = 12'((days / ecc_pkg::CYCLE_DAYS) * ecc_pkg::CYCLE_YEARS + row +
                                ecc_pkg::BASE_YEAR);
            res.cal.month = 4'(mon + 1);
            res.cal.day   = 5'(rem - ecc_pkg::MONTH_START[row][mon] + 1);
        end else begin
            bad = (rq.cal.year < ecc_pkg::BASE_YEAR) || (rq.cal.year > ecc_pkg::LAST_YEAR) ||
                  (rq.cal.month < 1) || (rq.cal.month > 12) ||
                  (rq.cal.hour >= ecc_pkg::HOUR_PER_DAY) ||
                  (rq.cal.minute >= ecc_pkg::SEC_PER_MIN) ||
                  (rq.cal.second >= ecc_pkg::SEC_PER_MIN) || (rq.cal.day < 1);
            if (!bad) begin
                yoff = rq.cal.year - ecc_pkg::BASE_YEAR;
                row  = yoff % ecc_pkg::CYCLE_YEARS;
                mon  = rq.cal.month - 1;
                bad  = (rq.cal.day > month_days(row, mon));
            end
            if (bad) begin
                res.err = 1'b1;
                return res;
            end
            days = longint'(yoff / ecc_pkg::CYCLE_YEARS) * ecc_pkg::CYCLE_DAYS +
                   ecc_pkg::MONTH_START[row][mon] + rq.cal.day - 1;
            secs = ((days * ecc_pkg::HOUR_PER_DAY + rq.cal.hour) * ecc_pkg::SEC_PER_MIN +
                    rq.cal.minute) * ecc_pkg::SEC_PER_MIN + rq.cal.second;
            res.epoch   = secs[31:0];
            res.cal     = rq.cal;
            res.weekday = weekday_of_day(days);
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request builders; unused fields carry random bits
    // ------------------------------------------------------------------

    function automatic t_conv_request epoch_request(input logic [31:0] secs);
        t_conv_request rq;
        rq.action = ecc_pkg::ACT_TO_CAL;
        rq.epoch  = secs;
        rq.cal    = 38'({$urandom, $urandom});
        return rq;
    endfunction

    function automatic t_conv_request cal_request(input int unsigned y, input int unsigned mo,
                                                  input int unsigned d, input int unsigned h,
                                                  input int unsigned mi, input int unsigned s);
        t_conv_request rq;
        rq.action     = ecc_pkg::ACT_TO_EPOCH;
        rq.epoch      = $urandom;
        rq.cal.year   = 12'(y);
        rq.cal.month  = 4'(mo);
        rq.cal.day    = 5'(d);
        rq.cal.hour   = 5'(h);
        rq.cal.minute = 6'(mi);
        rq.cal.second = 6'(s);
        return rq;
    endfunction

    // Mostly in range, some at month/year edges, at the top end, or fully random
    function automatic t_conv_request random_epoch_request();
        int unsigned   kind;
        logic [31:0]   base;
        t_conv_result  anchor;
        t_conv_request rq;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            rq = epoch_request($urandom);
        end else if (kind == 1) begin
            anchor = predict_conversion(cal_request($urandom_range(1970, 2099),
                                                    $urandom_range(1, 12), 1, 0, 0, 0));
            base = anchor.epoch;
            rq = epoch_request(base + $urandom_range(0, 4) - 2);
        end else if (kind == 2) begin
            rq = epoch_request(ecc_pkg::MAX_EPOCH - 3 + $urandom_range(0, 6));
        end else begin
            rq = epoch_request($urandom_range(ecc_pkg::MAX_EPOCH, 0));
        end
        return rq;
    endfunction

    // Mostly valid dates, some with one field out of range, some noise
    function automatic t_conv_request random_calendar_request();
        int unsigned   kind;
        int unsigned   y, mo, d, h, mi, s, len;
        t_conv_request rq;
        kind = $urandom_range(0, 9);
        y    = $urandom_range(1970, 2099);
        mo   = $urandom_range(1, 12);
        len  = month_days((y - ecc_pkg::BASE_YEAR) % ecc_pkg::CYCLE_YEARS, mo - 1);
        d    = ($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len);
        h    = $urandom_range(0, 23);
        mi   = $urandom_range(0, 59);
        s    = $urandom_range(0, 59);
        if (kind == 0) begin
            rq = cal_request($urandom_range(0, 4095), $urandom_range(0, 15),
                             $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 63), $urandom_range(0, 63));
        end else begin
            if (kind == 1) begin
                case ($urandom_range(0, 5))
                    0: y  = $urandom_range(0, 1) ? $urandom_range(2100, 4095)
                                                 : $urandom_range(0, 1969);
                    1: mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
                    2: d  = (len == 31 || $urandom_range(0, 1)) ? 0
                                                                : $urandom_range(len + 1, 31);
                    3: h  = $urandom_range(24, 31);
                    4: mi = $urandom_range(60, 63);
                    default: s = $urandom_range(60, 63);
                endcase
            end
            rq = cal_request(y, mo, d, h, mi, s);
        end
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: optional gap, then hold start until busy is low
    // ------------------------------------------------------------------
    task automatic send_request(input t_conv_request rq);
        int unsigned  gap;
        t_conv_result want;
        gap = gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_action           <= rq.action;
        i_epoch_seconds_in <= rq.epoch;
        i_year_in          <= rq.cal.year;
        i_month_in         <= rq.cal.month;
        i_day_in           <= rq.cal.day;
        i_hour_in          <= rq.cal.hour;
        i_minute_in        <= rq.cal.minute;
        i_second_in        <= rq.cal.second;
        start              <= 1'b1;
        do @(posedge i_clk); while (busy);
        want = predict_conversion(rq);
        expected_dates.push_back(want);
        if (rq.action == ecc_pkg::ACT_TO_CAL) n_split++;
        else n_build++;
        if (want.err) n_out_of_range++;
    endtask

    // Stop sending until every outstanding result has come back
    task automatic wait_until_drained();
        start <= 1'b0;
        while (expected_dates.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_conv_result want;
        if (o_strobe) begin
            if (expected_dates.size() == 0) begin
                fail_count++;
                $display("%0t: result with no request outstanding, expected none, actual %0d",
                         $time, o_epoch_seconds_out);
            end else begin
                want = expected_dates.pop_front();
                n_checked++;
                compare_field("epoch_seconds", want.epoch, o_epoch_seconds_out);
                compare_field("year", 32'(want.cal.year), 32'(o_year_out));
                compare_field("month", 32'(want.cal.month), 32'(o_month_out));
                compare_field("day", 32'(want.cal.day), 32'(o_day_out));
                compare_field("hour", 32'(want.cal.hour), 32'(o_hour_out));
                compare_field("minute", 32'(want.cal.minute), 32'(o_minute_out));
                compare_field("second", 32'(want.cal.second), 32'(o_second_out));
                compare_field("weekday", 32'(want.weekday), 32'(o_weekday_out));
                compare_field("range_error", 32'(want.err), 32'(o_range_error));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Seconds counts at the ends of the range and past it, plus a leap day and 2^31-1
    task automatic test_epoch_extremes();
        send_request(epoch_request(32'd0));
        send_request(epoch_request(ecc_pkg::MAX_EPOCH));
        send_request(epoch_request(ecc_pkg::MAX_EPOCH + 1));
        send_request(epoch_request(32'hFFFF_FFFF));
        send_request(epoch_request(32'd951782400));     // leap day 2000
        send_request(epoch_request(32'h7FFF_FFFF));
    endtask

    // First and last instants, leap days, and each field out of range, alone or all at once
    task automatic test_calendar_extremes();
        send_request(cal_request(1970, 1, 1, 0, 0, 0));
        send_request(cal_request(2099, 12, 31, 23, 59, 59));
        send_request(cal_request(2096, 2, 29, 12, 30, 30));
        send_request(cal_request(1972, 12, 31, 23, 59, 59));
        send_request(cal_request(2001, 2, 29, 0, 0, 0));
        send_request(cal_request(2000, 2, 30, 0, 0, 0));
        send_request(cal_request(2023, 4, 31, 0, 0, 0));
        send_request(cal_request(1969, 12, 31, 23, 59, 59));
        send_request(cal_request(2100, 1, 1, 0, 0, 0));
        send_request(cal_request(4095, 15, 31, 31, 63, 63));
        send_request(cal_request(0, 0, 0, 0, 0, 0));
        send_request(cal_request(2010, 13, 1, 0, 0, 0));
        send_request(cal_request(2010, 6, 0, 0, 0, 0));
        send_request(cal_request(2010, 6, 15, 24, 0, 0));
        send_request(cal_request(2010, 6, 15, 0, 60, 0));
        send_request(cal_request(2010, 6, 15, 0, 0, 60));
        send_request(cal_request(2010, 6, 15, 31, 63, 63));
    endtask

    task automatic test_random_split(input int unsigned count);
        repeat (count) send_request(random_epoch_request());
    endtask

    task automatic test_random_build(input int unsigned count);
        repeat (count) send_request(random_calendar_request());
    endtask

    // Both directions interleaved; gaps switched on and off in stretches
    task automatic test_mixed_bursts(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 40 == 0) gaps_on = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) send_request(random_epoch_request());
            else send_request(random_calendar_request());
        end
        gaps_on = 1'b1;
    endtask

    // Back-to-back burst, full drain, then restart from an empty pipeline
    task automatic test_pause_until_drained();
        gaps_on = 1'b0;
        repeat (8) send_request(random_calendar_request());
        wait_until_drained();
        repeat (4) send_request(random_epoch_request());
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        start              <= 1'b0;
        i_rst_n            <= 1'b0;
        i_action           <= ecc_pkg::ACT_TO_CAL;
        i_epoch_seconds_in <= '0;
        i_year_in          <= '0;
        i_month_in         <= '0;
        i_day_in           <= '0;
        i_hour_in          <= '0;
        i_minute_in        <= '0;
        i_second_in        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_epoch_extremes();
        test_calendar_extremes();
        test_random_split(370);
        test_pause_until_drained();
        test_random_build(370);
        test_mixed_bursts(170);

        wait_until_drained();
        repeat (2 * RESULT_LATENCY) @(posedge i_clk);

        $display("Covered %0d seconds-to-date and %0d date-to-seconds requests, %0d out of range.",
                 n_split, n_build, n_out_of_range);
        $display("%0d results compared field by field, %0d mismatches.", n_checked, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
